FILE: src/hmac_pkg.sv
// Package for the HMAC-SHA256 engine: sequencer types, SHA-256 constants and round functions.
`default_nettype none

package hmac_pkg;

  localparam logic [7:0] IPAD_BYTE = 8'h36;
  localparam logic [7:0] OPAD_BYTE = 8'h5c;
  localparam logic [7:0] PAD_BYTE  = 8'h80;

  localparam logic [31:0] IV_TBL [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K_TBL [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [3:0] {
    S_IDLE, S_ITEM, S_IPAD, S_KCLOSE, S_KZERO, S_KDONE, S_PAD80, S_PAD0,
    S_LEN, S_ROUND, S_ADD, S_OSTART, S_OPAD, S_INNER, S_OUT
  } state_e;

  typedef enum logic [1:0] {PH_IDLE, PH_KEY, PH_MSG} phase_e;

  typedef enum logic [1:0] {FIN_KEY, FIN_INNER, FIN_OUTER} fin_e;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] x);
    small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] x);
    small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

`default_nettype wire

FILE: src/hmac_sha256_engine.sv
// An input beat passes through the item state while input is stalled; the 64th byte of a block
// starts a compression (64 rounds of the single shared round unit, then one add).
// A message open adds 64 key bytes plus one compression; a message end adds the
// padding bytes, the outer hash (128 bytes with padding, two compressions), then
// 8 output words. Reset clears the key to all zeros and returns to idle at once.
`default_nettype none

module hmac_sha256_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        mode_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        byte_valid_i,
  input  wire logic        segment_end_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      digest_word_o,
  output logic [2:0]       word_index_o,
  output logic             last_word_o
);
  import hmac_pkg::*;

  state_e state_q, state_d, ret_q, ret_d, nxt;
  phase_e phase_q, phase_d;
  fin_e   fin_q, fin_d;

  logic [31:0]  h_q [8];
  logic [31:0]  h_d [8];
  logic [31:0]  w_q [8];
  logic [31:0]  w_d [8];
  logic [511:0] blk_q, blk_d;
  logic [511:0] ks_q, ks_d;
  logic [255:0] inner_q, inner_d;
  logic [63:0]  len_q, len_d;
  logic [5:0]   fill_q, fill_d;
  logic [6:0]   kc_q, kc_d;
  logic [5:0]   cnt_q, cnt_d;
  logic [5:0]   rnd_q, rnd_d;
  logic [2:0]   idx_q, idx_d;
  logic [7:0]   b_q, b_d;
  logic         v_q, v_d, e_q, e_d;

  logic         abs_en, abs_len;
  logic [7:0]   abs_byte;
  logic [31:0]  t1, t2, sched;

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = (state_q == S_OUT);
  assign digest_word_o = h_q[idx_q];
  assign word_index_o  = idx_q;
  assign last_word_o   = (idx_q == 3'd7);

  // Round unit and message schedule
  always_comb begin
    t1 = w_q[7] + big_s1(w_q[4]) + ((w_q[4] & w_q[5]) ^ (~w_q[4] & w_q[6]))
         + K_TBL[rnd_q] + blk_q[511:480];
    t2 = big_s0(w_q[0]) + ((w_q[0] & w_q[1]) ^ (w_q[0] & w_q[2]) ^ (w_q[1] & w_q[2]));
    sched = small_s1(blk_q[63:32]) + blk_q[223:192] + small_s0(blk_q[479:448])
            + blk_q[511:480];
  end

  // Sequencer
  always_comb begin
    nxt      = state_q;
    ret_d    = ret_q;
    phase_d  = phase_q;
    fin_d    = fin_q;
    h_d      = h_q;
    w_d      = w_q;
    blk_d    = blk_q;
    ks_d     = ks_q;
    inner_d  = inner_q;
    len_d    = len_q;
    fill_d   = fill_q;
    kc_d     = kc_q;
    cnt_d    = cnt_q;
    rnd_d    = rnd_q;
    idx_d    = idx_q;
    b_d      = b_q;
    v_d      = v_q;
    e_d      = e_q;
    abs_en   = 1'b0;
    abs_len  = 1'b0;
    abs_byte = 8'h00;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && (byte_valid_i || segment_end_i)) begin
          b_d = data_byte_i;
          v_d = byte_valid_i;
          e_d = segment_end_i;
          nxt = S_ITEM;
          if (phase_q == PH_IDLE) begin
            h_d    = IV_TBL;
            fill_d = '0;
            len_d  = '0;
            if (mode_i) begin
              phase_d = PH_MSG;
              cnt_d   = '0;
              nxt     = S_IPAD;
            end else begin
              phase_d = PH_KEY;
              ks_d    = '0;
              kc_d    = '0;
            end
          end
        end
      end
      S_IPAD: begin
        abs_en   = 1'b1;
        abs_len  = 1'b1;
        abs_byte = ks_q[511:504] ^ IPAD_BYTE;
        ks_d     = {ks_q[503:0], ks_q[511:504]};
        cnt_d    = cnt_q + 6'd1;
        if (cnt_q == 6'd63) nxt = S_ITEM;
      end
      S_ITEM: begin
        if (v_q) begin
          abs_en   = 1'b1;
          abs_len  = 1'b1;
          abs_byte = b_q;
        end
        if (phase_q == PH_KEY) begin
          if (v_q) begin
            if (kc_q < 7'd64) ks_d = {ks_q[503:0], b_q};
            if (kc_q < 7'd65) kc_d = kc_q + 7'd1;
          end
          nxt = e_q ? S_KCLOSE : S_IDLE;
        end else if (e_q) begin
          fin_d = FIN_INNER;
          nxt   = S_PAD80;
        end else begin
          nxt = S_IDLE;
        end
      end
      S_KCLOSE: begin
        if (kc_q > 7'd64) begin
          fin_d = FIN_KEY;
          nxt   = S_PAD80;
        end else begin
          nxt = S_KZERO;
        end
      end
      // align a short key so that its first byte sits on top
      S_KZERO: begin
        if (kc_q < 7'd64) begin
          ks_d = {ks_q[503:0], 8'h00};
          kc_d = kc_q + 7'd1;
        end else begin
          phase_d = PH_IDLE;
          nxt     = S_IDLE;
        end
      end
      S_KDONE: begin
        ks_d    = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4], h_q[5], h_q[6], h_q[7],
                   256'd0};
        phase_d = PH_IDLE;
        nxt     = S_IDLE;
      end
      S_PAD80: begin
        abs_en   = 1'b1;
        abs_byte = PAD_BYTE;
        nxt      = S_PAD0;
      end
      S_PAD0: begin
        if (fill_q == 6'd56) begin
          cnt_d = '0;
          nxt   = S_LEN;
        end else begin
          abs_en = 1'b1;
        end
      end
      S_LEN: begin
        abs_en   = 1'b1;
        abs_byte = len_q[{~cnt_q[2:0], 3'b000} +: 8];
        cnt_d    = cnt_q + 6'd1;
        if (cnt_q[2:0] == 3'd7) begin
          unique case (fin_q)
            FIN_KEY:   nxt = S_KDONE;
            FIN_INNER: nxt = S_OSTART;
            default: begin
              idx_d = '0;
              nxt   = S_OUT;
            end
          endcase
        end
      end
      S_OSTART: begin
        inner_d = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4], h_q[5], h_q[6], h_q[7]};
        h_d     = IV_TBL;
        fill_d  = '0;
        len_d   = '0;
        cnt_d   = '0;
        nxt     = S_OPAD;
      end
      S_OPAD: begin
        abs_en   = 1'b1;
        abs_len  = 1'b1;
        abs_byte = ks_q[511:504] ^ OPAD_BYTE;
        ks_d     = {ks_q[503:0], ks_q[511:504]};
        cnt_d    = cnt_q + 6'd1;
        if (cnt_q == 6'd63) nxt = S_INNER;
      end
      S_INNER: begin
        abs_en   = 1'b1;
        abs_len  = 1'b1;
        abs_byte = inner_q[255:248];
        inner_d  = {inner_q[247:0], 8'h00};
        cnt_d    = cnt_q + 6'd1;
        if (cnt_q == 6'd31) begin
          fin_d = FIN_OUTER;
          nxt   = S_PAD80;
        end
      end
      S_ROUND: begin
        w_d[7] = w_q[6];
        w_d[6] = w_q[5];
        w_d[5] = w_q[4];
        w_d[4] = w_q[3] + t1;
        w_d[3] = w_q[2];
        w_d[2] = w_q[1];
        w_d[1] = w_q[0];
        w_d[0] = t1 + t2;
        blk_d  = {blk_q[479:0], sched};
        rnd_d  = rnd_q + 6'd1;
        if (rnd_q == 6'd63) nxt = S_ADD;
      end
      S_ADD: begin
        for (int i = 0; i < 8; i++) h_d[i] = h_q[i] + w_q[i];
        nxt = ret_q;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            phase_d = PH_IDLE;
            nxt     = S_IDLE;
          end
        end
      end
      default: nxt = S_IDLE;
    endcase

    // byte absorb; a full block starts a compression and comes back after it
    if (abs_en) begin
      blk_d = {blk_q[503:0], abs_byte};
      if (abs_len) len_d = len_q + 64'd8;
      if (fill_q == 6'd63) begin
        fill_d = '0;
        w_d    = h_q;
        rnd_d  = '0;
        ret_d  = nxt;
        nxt    = S_ROUND;
      end else begin
        fill_d = fill_q + 6'd1;
      end
    end
    state_d = nxt;
  end

  // Control and key state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      phase_q <= PH_IDLE;
      fin_q   <= FIN_KEY;
      h_q     <= IV_TBL;
      ks_q    <= '0;
      len_q   <= '0;
      fill_q  <= '0;
      kc_q    <= '0;
      cnt_q   <= '0;
      rnd_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      phase_q <= phase_d;
      fin_q   <= fin_d;
      h_q     <= h_d;
      ks_q    <= ks_d;
      len_q   <= len_d;
      fill_q  <= fill_d;
      kc_q    <= kc_d;
      cnt_q   <= cnt_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    w_q     <= w_d;
    blk_q   <= blk_d;
    inner_q <= inner_d;
    b_q     <= b_d;
    v_q     <= v_d;
    e_q     <= e_d;
  end

`ifndef ASSERT_OFF
  a_out_in_msg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (phase_q == PH_MSG))
    else $error("digest output outside a message");

  a_round_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUND && rnd_q == 6'd63) |=> (state_q == S_ADD))
    else $error("compression did not end in the add step");

  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_word_o) |=> (!out_valid_o && !in_stall_o))
    else $error("output did not stop after the last word");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> !out_valid_o)
    else $error("input beat taken while digest pending");
`endif

endmodule

`default_nettype wire
